>>> src/dts_pkg.sv
// dts_pkg: shared types, register indexes and the set-match helper for the
// delimited token scanner. No dependencies.
package dts_pkg;

  localparam int unsigned SET_SIZE   = 4;
  localparam int unsigned SET_LANES  = 4;            // bytes packed in a set register
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned SET_N_W    = 3;

  localparam logic [SET_N_W-1:0] SET_LIMIT =
    (SET_SIZE < SET_LANES) ? SET_N_W'(SET_SIZE) : SET_N_W'(SET_LANES);

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_DELIM_CHARS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELIM_COUNT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_QUOTE_CHARS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_QUOTE_COUNT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EMPTY_TOKENS = 3'd4;

  typedef struct packed {
    logic [CHAR_W-1:0] char_in;
    logic              last_char;
  } in_t;

  typedef struct packed {
    logic [CHAR_W-1:0]  char_out;
    logic [COUNT_W-1:0] token_count;
    logic               token_start;
    logic               in_quote;
    logic               last_out;
  } out_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] delim_chars;
    logic [SET_N_W-1:0]    delim_count;
    logic [CFG_DATA_W-1:0] quote_chars;
    logic [SET_N_W-1:0]    quote_count;
    logic                  empty_tokens;
  } cfg_t;

  // parallel compare of one byte against the first n bytes (at most SET_LIMIT) of a packed set
  function automatic logic in_set(logic [CFG_DATA_W-1:0] packed_set,
                                  logic [SET_N_W-1:0] n,
                                  logic [CHAR_W-1:0] c);
    logic [SET_N_W-1:0] lim;
    logic               hit;
    lim = (n > SET_LIMIT) ? SET_LIMIT : n;
    hit = 1'b0;
    for (int i = 0; i < SET_LANES; i++) begin
      if ((SET_N_W'(i) < lim) && (packed_set[i*CHAR_W +: CHAR_W] == c)) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

>>> src/delimited_token_scanner.sv
// delimited_token_scanner: top level; input register, step logic, result register.
// Depends on dts_pkg, dts_cfg_regs, dts_step.
//
//   port group   dir   handshake            payload
//   in_*         in    in_valid/in_ready    in_data  (dts_pkg::in_t)
//   out_*        out   out_valid/out_ready  out_data (dts_pkg::out_t)
//   cfg_*        in    cfg_wr_en            cfg_index, cfg_wdata
//
// One byte per cycle sustained while the output is not stalled.
// The step logic runs as a beat moves from the input register to the result
// register; the scan state updates only then.
// A stalled output holds its beat while the input register takes one more.
// Synchronous reset empties both registers and restores the register defaults.
module delimited_token_scanner (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  dts_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output dts_pkg::out_t                  out_data,
  input  logic                           cfg_wr_en,
  input  logic [dts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dts_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  dts_pkg::cfg_t cfg;
  dts_pkg::in_t  hold_item;
  dts_pkg::out_t step_result;
  logic          hold_valid;
  logic          advance;

  assign advance  = hold_valid && (!out_valid || out_ready);
  assign in_ready = !hold_valid || advance;

  dts_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  dts_step u_step (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (hold_item),
    .cfg     (cfg),
    .result  (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_item <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= step_result;
    end
  end

endmodule

>>> src/dts_cfg_regs.sv
// dts_cfg_regs: configuration register file of the token scanner.
// Depends on dts_pkg.
module dts_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [dts_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dts_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output dts_pkg::cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.delim_chars  <= dts_pkg::CFG_DATA_W'(32);
      cfg.delim_count  <= dts_pkg::SET_N_W'(1);
      cfg.quote_chars  <= dts_pkg::CFG_DATA_W'(34);
      cfg.quote_count  <= '0;
      cfg.empty_tokens <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        dts_pkg::REG_DELIM_CHARS:  cfg.delim_chars  <= cfg_wdata;
        dts_pkg::REG_DELIM_COUNT:  cfg.delim_count  <= cfg_wdata[dts_pkg::SET_N_W-1:0];
        dts_pkg::REG_QUOTE_CHARS:  cfg.quote_chars  <= cfg_wdata;
        dts_pkg::REG_QUOTE_COUNT:  cfg.quote_count  <= cfg_wdata[dts_pkg::SET_N_W-1:0];
        dts_pkg::REG_EMPTY_TOKENS: cfg.empty_tokens <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

endmodule

>>> src/dts_step.sv
// dts_step: per-string scan state and the combinational step logic.
// Depends on dts_pkg.
module dts_step (
  input  logic          clk,
  input  logic          rst,
  input  logic          advance,
  input  dts_pkg::in_t  item,
  input  dts_pkg::cfg_t cfg,
  output dts_pkg::out_t result
);

  logic                             in_run, in_run_next;
  logic                             quote_open, quote_open_next;
  logic [dts_pkg::CHAR_W-1:0]       quote_byte, quote_byte_next;
  logic                             after_close, after_close_next;
  logic [dts_pkg::COUNT_W-1:0]      running_count, running_count_next;
  logic                             string_start, string_start_next;

  logic                             empty_mode, q_hit, d_hit, started, inq;
  logic [dts_pkg::CHAR_W-1:0]       cout;
  logic [dts_pkg::COUNT_W-1:0]      cnt;
  logic                             run_now;
  logic                             can_bump;

  always_comb begin
    empty_mode = cfg.empty_tokens;
    q_hit      = dts_pkg::in_set(cfg.quote_chars, cfg.quote_count, item.char_in);
    d_hit      = dts_pkg::in_set(cfg.delim_chars, cfg.delim_count, item.char_in);

    // first byte of a string starts from a fresh count
    cnt      = string_start ? dts_pkg::COUNT_W'(empty_mode) : running_count;
    run_now  = string_start ? 1'b0 : in_run;
    can_bump = (cnt != dts_pkg::COUNT_MAX);

    cout             = item.char_in;
    started          = 1'b0;
    inq              = 1'b0;
    quote_open_next  = quote_open;
    quote_byte_next  = quote_byte;
    after_close_next = after_close;
    in_run_next      = run_now;
    running_count_next = cnt;

    if (quote_open) begin
      inq = 1'b1;
      if (item.char_in == quote_byte) begin
        quote_open_next  = 1'b0;
        after_close_next = 1'b1;
      end
    end else if (!after_close && q_hit) begin
      quote_open_next = 1'b1;
      quote_byte_next = item.char_in;
      inq             = 1'b1;
    end else begin
      after_close_next = 1'b0;
      if (d_hit) begin
        cout = '0;
      end
      if (empty_mode) begin
        if (d_hit && can_bump) begin
          running_count_next = cnt + 1'b1;
          started            = 1'b1;
        end
      end else if (cout != '0) begin
        if (!run_now) begin
          if (can_bump) begin
            running_count_next = cnt + 1'b1;
            started            = 1'b1;
          end
          in_run_next = 1'b1;
        end
      end else begin
        in_run_next = 1'b0;
      end
    end

    result.char_out    = cout;
    result.token_count = running_count_next;
    result.token_start = started;
    result.in_quote    = inq;
    result.last_out    = item.last_char;
    string_start_next  = 1'b0;

    if (item.last_char) begin
      in_run_next        = 1'b0;
      quote_open_next    = 1'b0;
      quote_byte_next    = '0;
      after_close_next   = 1'b0;
      running_count_next = '0;
      string_start_next  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_run        <= 1'b0;
      quote_open    <= 1'b0;
      quote_byte    <= '0;
      after_close   <= 1'b0;
      running_count <= '0;
      string_start  <= 1'b1;
    end else if (advance) begin
      in_run        <= in_run_next;
      quote_open    <= quote_open_next;
      quote_byte    <= quote_byte_next;
      after_close   <= after_close_next;
      running_count <= running_count_next;
      string_start  <= string_start_next;
    end
  end

endmodule

>>> src/dts_checker.sv
// dts_checker: port-level assertions for the token scanner, bound to the top.
// Depends on dts_pkg and delimited_token_scanner.
module dts_checker (
  input logic          clk,
  input logic          rst,
  input logic          out_valid,
  input logic          out_ready,
  input dts_pkg::out_t out_data
);

  // a waiting result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid straight after reset");

  a_start_counts: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.token_start |-> out_data.token_count != '0)
    else $error("token start with zero count");

  // quoted bytes are never counted
  a_quote_no_start: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.in_quote |-> !out_data.token_start)
    else $error("token start inside quoted span");

endmodule

bind delimited_token_scanner dts_checker u_dts_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
